@@ rtl/hmm_forward_log_likelihood_defines.svh @@
// assertion macros used by the top-level rtl file
`ifndef HMM_FORWARD_LOG_LIKELIHOOD_DEFINES_SVH
`define HMM_FORWARD_LOG_LIKELIHOOD_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define HFLL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define HFLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hfll_pkg.sv @@
// ----------------------------------------------------------------------------
// hfll_pkg
// shared types and constants of the log-domain hmm forward scorer
// ----------------------------------------------------------------------------
`default_nettype none

package hfll_pkg;

    // minus infinity and the largest score
    localparam logic signed [31:0] NEG     = 32'sh8000_0000;
    localparam logic signed [31:0] MAX_POS = 32'sh7fff_ffff;

    // configuration register indexes
    localparam logic [2:0] REG_STATE_COUNT = 3'd0;
    localparam logic [2:0] REG_LOG_INITIAL = 3'd1;
    localparam logic [2:0] REG_TRANS_ROW0  = 3'd2;
    localparam logic [2:0] REG_TRANS_ROW1  = 3'd3;
    localparam logic [2:0] REG_TRANS_ROW2  = 3'd4;
    localparam logic [2:0] REG_EMIT_ROW0   = 3'd5;
    localparam logic [2:0] REG_EMIT_ROW1   = 3'd6;
    localparam logic [2:0] REG_EMIT_ROW2   = 3'd7;

    // correction of log-sum-exp, indexed by the difference >> 8
    localparam int CORR_LEN = 32;
    localparam logic [9:0] CORR_TABLE [0:CORR_LEN-1] = '{
        10'd710, 10'd590, 10'd485, 10'd396, 10'd321, 10'd258, 10'd206, 10'd164,
        10'd130, 10'd103, 10'd81,  10'd63,  10'd50,  10'd39,  10'd30,  10'd24,
        10'd19,  10'd15,  10'd11,  10'd9,   10'd7,   10'd5,   10'd4,   10'd3,
        10'd3,   10'd2,   10'd2,   10'd1,   10'd1,   10'd1,   10'd1,   10'd0
    };

    typedef enum logic {
        OP_ADD,
        OP_LSE
    } t_alu_op;

    typedef enum logic [1:0] {
        WORD_INIT,
        WORD_TRANS,
        WORD_EMIT
    } t_word_kind;

    // table word request to the configuration file
    typedef struct packed {
        t_word_kind kind;
        logic [1:0] row;
        logic [1:0] col;
    } t_word_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_TERM,
        S_ACC,
        S_EMIT,
        S_COMMIT,
        S_TOTAL
    } t_state;

endpackage

`default_nettype wire

@@ rtl/hfll_alu.sv @@
// ----------------------------------------------------------------------------
// hfll_alu
// shared saturating add and log-sum-exp unit
// ----------------------------------------------------------------------------
`default_nettype none

module hfll_alu
    import hfll_pkg::*;
(
    input  wire t_alu_op            i_op,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [31:0]      o_y
);

    localparam logic signed [32:0] MIN33 = -33'sd2147483648;
    localparam logic signed [32:0] MAX33 = 33'sd2147483647;

    logic signed [31:0] w_max;
    logic signed [31:0] w_min;
    logic signed [32:0] w_sum;
    logic signed [32:0] w_diff;
    logic signed [32:0] w_lse;
    logic [9:0]         w_corr;

    assign w_sum  = 33'(i_a) + 33'(i_b);
    assign w_max  = (i_a > i_b) ? i_a : i_b;
    assign w_min  = (i_a > i_b) ? i_b : i_a;
    assign w_diff = 33'(w_max) - 33'(w_min);
    // correction is zero once the difference reaches 8.0
    assign w_corr = (w_diff[32:13] == '0) ? CORR_TABLE[w_diff[12:8]] : 10'd0;
    assign w_lse  = 33'(w_max) + $signed({23'd0, w_corr});

    always_comb begin
        case (i_op)
            OP_ADD: begin
                if (i_a == NEG || i_b == NEG) begin
                    o_y = NEG;
                end else if (w_sum <= MIN33) begin
                    o_y = NEG;
                end else if (w_sum > MAX33) begin
                    o_y = MAX_POS;
                end else begin
                    o_y = w_sum[31:0];
                end
            end
            OP_LSE: begin
                if (i_a == NEG) begin
                    o_y = i_b;
                end else if (i_b == NEG) begin
                    o_y = i_a;
                end else if (w_lse > MAX33) begin
                    o_y = MAX_POS;
                end else begin
                    o_y = w_lse[31:0];
                end
            end
            default: begin
                o_y = NEG;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/hfll_cfg.sv @@
// ----------------------------------------------------------------------------
// hfll_cfg
// configuration registers and table word decode
// ----------------------------------------------------------------------------
`default_nettype none

module hfll_cfg
    import hfll_pkg::*;
#(
    parameter int LOG_WORD_BITS = 16,
    parameter int USED_STATES   = 3,
    parameter int SIDX_W        = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data,
    input  wire t_word_req          i_req,
    output logic signed [31:0]      o_word,
    output logic [SIDX_W-1:0]       o_last_state
);

    localparam int W = LOG_WORD_BITS;

    logic [1:0]  r_state_count;
    logic [47:0] r_initial;
    logic [47:0] r_trans [0:2];
    logic [63:0] r_emit  [0:2];
    logic [63:0] w_reg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= 2'd2;
            r_initial     <= '0;
            for (int k = 0; k < 3; k++) begin
                r_trans[k] <= '0;
                r_emit[k]  <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_STATE_COUNT: r_state_count <= i_cfg_data[1:0];
                REG_LOG_INITIAL: r_initial     <= i_cfg_data[47:0];
                REG_TRANS_ROW0:  r_trans[0]    <= i_cfg_data[47:0];
                REG_TRANS_ROW1:  r_trans[1]    <= i_cfg_data[47:0];
                REG_TRANS_ROW2:  r_trans[2]    <= i_cfg_data[47:0];
                REG_EMIT_ROW0:   r_emit[0]     <= i_cfg_data;
                REG_EMIT_ROW1:   r_emit[1]     <= i_cfg_data;
                REG_EMIT_ROW2:   r_emit[2]     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // zero means one state, clamp to the states held
    always_comb begin
        if (r_state_count == 2'd0) begin
            o_last_state = '0;
        end else if (int'(r_state_count) > USED_STATES) begin
            o_last_state = SIDX_W'(USED_STATES - 1);
        end else begin
            o_last_state = SIDX_W'(int'(r_state_count) - 1);
        end
    end

    // signed word of the packed register, log zero maps to minus infinity
    function automatic logic signed [31:0] word_at(input logic [63:0] r, input logic [1:0] col);
        logic [63:0]  sh;
        logic [W-1:0] raw;
        logic         fits;
        sh   = r >> (int'(col) * W);
        raw  = W'(sh);
        fits = ((int'(col) + 1) * W) <= 64;
        if (!fits) begin
            return '0;
        end
        if (raw == {1'b1, {(W-1){1'b0}}}) begin
            return NEG;
        end
        return 32'($signed(raw));
    endfunction

    always_comb begin
        w_reg = '0;
        case (i_req.kind)
            WORD_INIT: w_reg = {16'd0, r_initial};
            WORD_TRANS: begin
                case (i_req.row)
                    2'd0:    w_reg = {16'd0, r_trans[0]};
                    2'd1:    w_reg = {16'd0, r_trans[1]};
                    2'd2:    w_reg = {16'd0, r_trans[2]};
                    default: w_reg = '0;
                endcase
            end
            WORD_EMIT: begin
                case (i_req.row)
                    2'd0:    w_reg = r_emit[0];
                    2'd1:    w_reg = r_emit[1];
                    2'd2:    w_reg = r_emit[2];
                    default: w_reg = '0;
                endcase
            end
            default: w_reg = '0;
        endcase
    end

    assign o_word = word_at(w_reg, i_req.col);

endmodule

`default_nettype wire

@@ rtl/hmm_forward_log_likelihood.sv @@
// a first symbol runs an init and an emission step per state, a later one a transition and
// an accumulate step per source before each emission, then a commit; the input is stalled
// until idle; a last symbol adds a total pass and any wait on a full result register
// the next symbol is taken while a finished result still waits in the output register
// reset (synchronous, active low): scores zero, flag clear, state count two, tables zero
// ----------------------------------------------------------------------------
// hmm_forward_log_likelihood
// log-domain forward scorer of a small hidden markov model over dna symbols
// ----------------------------------------------------------------------------
`default_nettype none
`include "hmm_forward_log_likelihood_defines.svh"

module hmm_forward_log_likelihood
    import hfll_pkg::*;
#(
    parameter int MAX_STATES    = 3,
    parameter int LOG_WORD_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data,
    // symbol channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_symbol,
    input  wire logic               i_first,
    input  wire logic               i_last,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_log_likelihood,
    output logic                    o_saturated
);

    // the tables hold three states, so no more scores are ever used
    localparam int USED_STATES = (MAX_STATES < 3) ? MAX_STATES : 3;
    localparam int SIDX_W      = (USED_STATES > 1) ? $clog2(USED_STATES) : 1;

    t_state r_state;
    t_state n_state;

    // latched symbol transfer
    logic [1:0] r_sym;
    logic       r_first;
    logic       r_last;

    // source and destination counters
    logic [SIDX_W-1:0] r_i;
    logic [SIDX_W-1:0] r_j;
    logic [SIDX_W-1:0] w_last_state;

    // scores, new scores, accumulator and transition term
    logic signed [31:0] r_score [0:USED_STATES-1];
    logic signed [31:0] r_next  [0:USED_STATES-1];
    logic signed [31:0] r_acc;
    logic signed [31:0] r_term;
    logic               r_sat;

    logic               w_accept;
    logic               w_out_free;
    logic               w_i_end;
    logic               w_j_end;
    logic               w_load_result;
    logic               w_commit_neg;

    t_word_req          w_req;
    logic signed [31:0] w_word;
    t_alu_op            w_op;
    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic signed [31:0] w_y;

    assign w_accept      = i_in_valid && !o_in_stall;
    assign w_out_free    = !o_out_valid || !i_out_stall;
    assign w_i_end       = (r_i == w_last_state);
    assign w_j_end       = (r_j == w_last_state);
    // last step of the total with room in the result register
    assign w_load_result = (r_state == S_TOTAL) && w_j_end && w_out_free;

    hfll_cfg #(
        .LOG_WORD_BITS (LOG_WORD_BITS),
        .USED_STATES   (USED_STATES),
        .SIDX_W        (SIDX_W)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req        (w_req),
        .o_word       (w_word),
        .o_last_state (w_last_state)
    );

    hfll_alu u_alu (
        .i_op (w_op),
        .i_a  (w_a),
        .i_b  (w_b),
        .o_y  (w_y)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_first ? S_INIT : S_TERM;
                end
            end
            S_INIT: n_state = S_EMIT;
            S_TERM: n_state = S_ACC;
            S_ACC:  n_state = w_i_end ? S_EMIT : S_TERM;
            S_EMIT: begin
                if (w_j_end) begin
                    n_state = S_COMMIT;
                end else begin
                    n_state = r_first ? S_INIT : S_TERM;
                end
            end
            S_COMMIT: n_state = r_last ? S_TOTAL : S_IDLE;
            S_TOTAL: begin
                if (w_j_end && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // table word and shared unit operands for each step
    always_comb begin
        w_req.kind = WORD_INIT;
        w_req.row  = '0;
        w_req.col  = 2'(r_j);
        w_op       = OP_ADD;
        w_a        = r_acc;
        w_b        = w_word;
        case (r_state)
            S_INIT: begin
                w_req.kind = WORD_INIT;
            end
            S_TERM: begin
                // score of source i plus transition i to j
                w_req.kind = WORD_TRANS;
                w_req.row  = 2'(r_i);
                w_op       = OP_ADD;
                w_a        = r_score[r_i];
            end
            S_ACC: begin
                w_op = OP_LSE;
                w_b  = r_term;
            end
            S_EMIT: begin
                // add emission of the latched symbol in state j
                w_req.kind = WORD_EMIT;
                w_req.row  = 2'(r_j);
                w_req.col  = r_sym;
                w_op       = OP_ADD;
            end
            S_TOTAL: begin
                w_op = OP_LSE;
                w_b  = r_score[r_j];
            end
            default: begin
            end
        endcase
    end

    // any new score of a state in use at minus infinity
    always_comb begin
        w_commit_neg = 1'b0;
        for (int k = 0; k < USED_STATES; k++) begin
            if ((SIDX_W'(k) <= w_last_state) && (r_next[k] == NEG)) begin
                w_commit_neg = 1'b1;
            end
        end
    end

    // control state, scores and flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_sat       <= 1'b0;
            o_out_valid <= 1'b0;
            for (int k = 0; k < USED_STATES; k++) begin
                r_score[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            // result leaves on a transfer, a new one may load in the same cycle
            if (w_load_result) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_i <= '0;
                        r_j <= '0;
                        if (i_first) begin
                            r_sat <= 1'b0;
                        end
                    end
                end
                S_ACC: begin
                    r_i <= w_i_end ? '0 : SIDX_W'(r_i + 1'b1);
                end
                S_EMIT: begin
                    r_i <= '0;
                    r_j <= w_j_end ? '0 : SIDX_W'(r_j + 1'b1);
                end
                S_COMMIT: begin
                    // states beyond the count keep their scores
                    for (int k = 0; k < USED_STATES; k++) begin
                        if (SIDX_W'(k) <= w_last_state) begin
                            r_score[k] <= r_next[k];
                        end
                    end
                    if (w_commit_neg) begin
                        r_sat <= 1'b1;
                    end
                    r_j <= '0;
                end
                S_TOTAL: begin
                    if (!w_j_end) begin
                        r_j <= SIDX_W'(r_j + 1'b1);
                    end else if (w_out_free) begin
                        r_j <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_sym   <= i_symbol;
                    r_first <= i_first;
                    r_last  <= i_last;
                    r_acc   <= NEG;
                end
            end
            S_INIT: r_acc  <= w_word;
            S_TERM: r_term <= w_y;
            S_ACC:  r_acc  <= w_y;
            S_EMIT: begin
                r_next[r_j] <= w_y;
                // each destination chain starts from minus infinity
                r_acc       <= NEG;
            end
            S_COMMIT: r_acc <= NEG;
            S_TOTAL: begin
                if (!w_j_end) begin
                    r_acc <= w_y;
                end else if (w_out_free) begin
                    o_log_likelihood <= w_y;
                    o_saturated      <= r_sat || (w_y == NEG);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    `HFLL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, o_in_stall, "accepted symbol did not make the block busy")
    `HFLL_ASSERT_SAME(a_result_needs_last, i_clk, i_rst_n, $rose(o_out_valid), r_last, "result raised for a symbol not marked last")
    `HFLL_ASSERT_NEXT(a_commit_no_last, i_clk, i_rst_n, (r_state == S_COMMIT) && !r_last, r_state == S_IDLE, "total pass entered without last")
    `HFLL_ASSERT_SAME(a_neg_sets_flag, i_clk, i_rst_n, o_out_valid && !o_saturated, o_log_likelihood != NEG, "minus infinity result without saturation flag")

endmodule

`default_nettype wire

@@ dv/hmm_forward_log_likelihood_tb.sv @@
// ----------------------------------------------------------------------------
// hmm_forward_log_likelihood_tb
// self-checking bench: predicts the log likelihood of each symbol sequence
// with a local log-domain forward scorer and compares every result transfer
// ----------------------------------------------------------------------------
module hmm_forward_log_likelihood_tb;
    import hfll_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS      = 16;
    localparam int STATES         = 3;
    localparam int DRAIN_CYCLES   = 40;    // outlasts a later symbol plus its total for three states
    localparam int LONG_HOLD      = 400;   // receiver hold-off in the pressure phase
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_SYMBOLS  = 145;

    typedef struct {
        logic signed [31:0] total;
        logic               sat;
    } t_likelihood;

    // local forward scorer plus the queue of likelihoods it expects
    class forward_score_model;
        logic [1:0]    state_count;
        logic [63:0]   initial_words;
        logic [63:0]   trans_rows [STATES];
        logic [63:0]   emit_rows [STATES];
        int            score [STATES];
        bit            sat_seen;
        t_likelihood   expected_totals [$];
        int            errors;
        int            checked;
        int            saturated_totals;

        function new();
            state_count   = 2'd2;
            initial_words = '0;
            for (int k = 0; k < STATES; k++) begin
                trans_rows[k] = '0;
                emit_rows[k]  = '0;
                score[k]      = 0;
            end
            sat_seen         = 1'b0;
            errors           = 0;
            checked          = 0;
            saturated_totals = 0;
        endfunction

        // signed q5.10 word, the most negative pattern stands for log 0
        function int word_of(logic [63:0] bits, int idx);
            logic [WORD_BITS-1:0] raw;
            raw = bits[idx*WORD_BITS +: WORD_BITS];
            if (raw == {1'b1, {(WORD_BITS-1){1'b0}}})
                return NEG;
            return int'($signed(raw));
        endfunction

        function int add_sat(int a, int b);
            longint s;
            if (a == NEG || b == NEG)
                return NEG;
            s = longint'(a) + longint'(b);
            if (s <= longint'(NEG))
                return NEG;
            if (s > longint'(MAX_POS))
                return MAX_POS;
            return int'(s);
        endfunction

        // max plus table correction on the difference
        function int log_sum(int a, int b);
            int     hi;
            int     lo;
            longint d;
            longint c;
            longint s;
            if (a == NEG)
                return b;
            if (b == NEG)
                return a;
            hi = (a > b) ? a : b;
            lo = (a > b) ? b : a;
            d  = longint'(hi) - longint'(lo);
            c  = 0;
            if (d < (longint'(CORR_LEN) << 8))
                c = longint'(CORR_TABLE[int'(d >> 8)]);
            s = longint'(hi) + c;
            if (s > longint'(MAX_POS))
                return MAX_POS;
            return int'(s);
        endfunction

        function int states_in_use();
            int n;
            n = (state_count == 2'd0) ? 1 : int'(state_count);
            if (n > STATES)
                n = STATES;
            return n;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                REG_STATE_COUNT: state_count = data[1:0];
                REG_LOG_INITIAL: initial_words = {16'h0, data[47:0]};
                REG_TRANS_ROW0:  trans_rows[0] = {16'h0, data[47:0]};
                REG_TRANS_ROW1:  trans_rows[1] = {16'h0, data[47:0]};
                REG_TRANS_ROW2:  trans_rows[2] = {16'h0, data[47:0]};
                REG_EMIT_ROW0:   emit_rows[0] = data;
                REG_EMIT_ROW1:   emit_rows[1] = data;
                REG_EMIT_ROW2:   emit_rows[2] = data;
                default: ;
            endcase
        endfunction

        // one accepted symbol: advance the scores, queue a likelihood on last
        function void note_input(logic [1:0] sym, logic first, logic last);
            int          n;
            int          acc;
            int          total;
            int          nxt [STATES];
            t_likelihood want;
            n = states_in_use();
            if (first)
                sat_seen = 1'b0;
            for (int j = 0; j < n; j++) begin
                if (first) begin
                    acc = word_of(initial_words, j);
                end else begin
                    acc = NEG;
                    for (int i = 0; i < n; i++)
                        acc = log_sum(acc, add_sat(score[i], word_of(trans_rows[i], j)));
                end
                nxt[j] = add_sat(acc, word_of(emit_rows[j], int'(sym)));
            end
            for (int j = 0; j < n; j++) begin
                score[j] = nxt[j];
                if (nxt[j] == NEG)
                    sat_seen = 1'b1;
            end
            if (last) begin
                total = NEG;
                for (int j = 0; j < n; j++)
                    total = log_sum(total, score[j]);
                want.total = total;
                want.sat   = sat_seen || (total == NEG);
                expected_totals.push_back(want);
            end
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] %s", $time, what);
        endfunction

        function void check_result(logic signed [31:0] total, logic sat);
            t_likelihood want;
            if (expected_totals.size() == 0) begin
                flag($sformatf("unexpected result: total %0d sat %0b", total, sat));
                return;
            end
            want = expected_totals.pop_front();
            checked++;
            if (want.sat)
                saturated_totals++;
            if (total !== want.total || sat !== want.sat)
                flag($sformatf("mismatch: expected total %0d sat %0b, got total %0d sat %0b",
                               want.total, want.sat, total, sat));
        endfunction

        function int pending();
            return expected_totals.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_symbol;
    logic               i_first;
    logic               i_last;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_log_likelihood;
    logic               o_saturated;

    forward_score_model sb = new();

    // flags shared between the sender and the receiver, and run counters
    bit no_idle;
    bit hold_request;
    int symbols_sent;
    int models_loaded;
    int idle_cycles;

    hmm_forward_log_likelihood uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_symbol         (i_symbol),
        .i_first          (i_first),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_log_likelihood (o_log_likelihood),
        .o_saturated      (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(15, 4);
        return $urandom_range(60, 20);
    endfunction

    // table word biased toward log 0, the extremes and plausible log probabilities
    function automatic logic [15:0] rand_word(int zero_pct);
        int r;
        r = $urandom_range(99);
        if (r < zero_pct)
            return 16'h8000;
        r = $urandom_range(99);
        if (r < 8)
            return 16'h7fff;
        if (r < 13)
            return 16'h8001;
        if (r < 18)
            return 16'h0000;
        if (r < 75)
            return 16'(0 - int'($urandom_range(8192)));
        return 16'($urandom);
    endfunction

    function automatic logic [47:0] rand_row3(int zero_pct);
        return {rand_word(zero_pct), rand_word(zero_pct), rand_word(zero_pct)};
    endfunction

    function automatic logic [63:0] rand_row4(int zero_pct);
        return {rand_word(zero_pct), rand_word(zero_pct),
                rand_word(zero_pct), rand_word(zero_pct)};
    endfunction

    // writes all eight registers back to back, unused upper bits get noise
    task automatic load_model(input logic [1:0] count, input logic [47:0] init,
                              input logic [47:0] t0, input logic [47:0] t1,
                              input logic [47:0] t2, input logic [63:0] e0,
                              input logic [63:0] e1, input logic [63:0] e2);
        logic [63:0] reg_image [8];
        reg_image[REG_STATE_COUNT]      = {$urandom, $urandom};
        reg_image[REG_STATE_COUNT][1:0] = count;
        reg_image[REG_LOG_INITIAL]      = {16'($urandom), init};
        reg_image[REG_TRANS_ROW0]       = {16'($urandom), t0};
        reg_image[REG_TRANS_ROW1]       = {16'($urandom), t1};
        reg_image[REG_TRANS_ROW2]       = {16'($urandom), t2};
        reg_image[REG_EMIT_ROW0]        = e0;
        reg_image[REG_EMIT_ROW1]        = e1;
        reg_image[REG_EMIT_ROW2]        = e2;
        for (int k = REG_STATE_COUNT; k <= REG_EMIT_ROW2; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(k);
            i_cfg_data  <= reg_image[k];
            @(posedge i_clk);
            sb.write_reg(3'(k), reg_image[k]);
        end
        i_cfg_we <= 1'b0;
        models_loaded++;
    endtask

    // one symbol transfer, preceded by a random gap
    task automatic send_symbol(input logic [1:0] sym, input logic first, input logic last);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_symbol   <= sym;
        i_first    <= first;
        i_last     <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_input(sym, first, last);
        symbols_sent++;
    endtask

    // sender goes quiet until every queued likelihood has come back
    task automatic pause_until_empty();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    // idle point for register writes: a symbol without last may still be in flight
    task automatic wait_drained();
        pause_until_empty();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int target);
        int count;
        int len;
        int r;
        count = 0;
        while (count < target) begin
            r = $urandom_range(99);
            if (r < 80) begin
                // well-formed sequence, now and then a long one
                len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
                for (int k = 0; k < len; k++)
                    send_symbol(2'($urandom), k == 0, k == len - 1);
                count += len;
                if ($urandom_range(9) == 0)
                    pause_until_empty();
            end else if (r < 92) begin
                // noise: any mix of first and last
                send_symbol(2'($urandom), 1'($urandom), 1'($urandom));
                count++;
            end else begin
                // sequence opened and never closed
                len = $urandom_range(5, 1);
                for (int k = 0; k < len; k++)
                    send_symbol(2'($urandom), k == 0, 1'b0);
                count += len;
            end
        end
    endtask

    // result side: check each transfer, then pick the next stall level
    initial begin
        int  stall_left;
        bit  stall_level;
        int  gap;
        stall_left  = 0;
        stall_level = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
                sb.check_result(o_log_likelihood, o_saturated);
            if (hold_request) begin
                // long hold-off so the block fills up and stalls its input
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
                stall_level  = 1'b1;
            end else if (stall_left == 0) begin
                gap = pick_gap();
                if (no_idle || gap == 0) begin
                    stall_level = 1'b0;
                    stall_left  = $urandom_range(12, 1);
                end else begin
                    stall_level = 1'b1;
                    stall_left  = gap;
                end
            end
            stall_left--;
            i_out_stall <= stall_level;
        end
    end

    // watchdog: ends the run after too long without any transfer
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [47:0] m_init;
        logic [47:0] m_t0;
        logic [47:0] m_t1;
        logic [47:0] m_t2;
        logic [63:0] m_e0;
        logic [63:0] m_e1;
        logic [63:0] m_e2;
        int          zero_pct;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_symbol     <= '0;
        i_first      <= 1'b0;
        i_last       <= 1'b0;
        i_out_stall  <= 1'b0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        symbols_sent = 0;
        models_loaded = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset tables: two states, all words zero
        // symbols without first continue from the zero scores left by reset
        send_symbol(2'd0, 1'b0, 1'b0);
        send_symbol(2'd3, 1'b0, 1'b1);
        send_symbol(2'd1, 1'b1, 1'b1);   // one-symbol sequence
        send_symbol(2'd2, 1'b1, 1'b0);
        send_symbol(2'd1, 1'b0, 1'b0);
        send_symbol(2'd3, 1'b0, 1'b1);

        // mixed model: log 0, largest word, most negative finite word
        m_init = {16'h8000, 16'h7fff, 16'hfc00};
        m_t0   = {16'h8001, 16'hf800, 16'hff00};
        m_t1   = {16'h8000, 16'h0000, 16'hfe00};
        m_t2   = {16'hfa00, 16'hfd00, 16'h8000};
        m_e0   = {16'h8000, 16'h7fff, 16'h8001, 16'h0000};
        m_e1   = {16'hf600, 16'hfe00, 16'hff00, 16'hfc00};
        m_e2   = {16'hfe00, 16'h8000, 16'hff80, 16'hfa00};
        wait_drained();
        load_model(2'd3, m_init, m_t0, m_t1, m_t2, m_e0, m_e1, m_e2);
        for (int k = 0; k < 4; k++)
            send_symbol(2'(k), k == 0, k == 3);
        send_symbol(2'd2, 1'b1, 1'b1);
        send_symbol(2'd3, 1'b1, 1'b1);

        // every word log 0: total is minus infinity, flag set
        wait_drained();
        load_model(2'd3, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                   {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        send_symbol(2'd0, 1'b1, 1'b1);
        send_symbol(2'd3, 1'b1, 1'b0);
        send_symbol(2'd1, 1'b0, 1'b1);

        // every word at its largest value
        wait_drained();
        load_model(2'd3, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}},
                   {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
        for (int k = 0; k < 3; k++)
            send_symbol(2'(k + 1), k == 0, k == 2);

        // state count zero behaves as one state, then one state proper
        wait_drained();
        load_model(2'd0, m_init, m_t0, m_t1, m_t2, m_e0, m_e1, m_e2);
        for (int k = 0; k < 3; k++)
            send_symbol(2'(3 - k), k == 0, k == 2);
        wait_drained();
        load_model(2'd1, m_init, m_t0, m_t1, m_t2, m_e0, m_e1, m_e2);
        send_symbol(2'd2, 1'b1, 1'b0);
        send_symbol(2'd0, 1'b0, 1'b1);

        // random models and sequences
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            case ($urandom_range(2))
                0:       zero_pct = 0;
                1:       zero_pct = 3;
                default: zero_pct = 15;
            endcase
            load_model(2'($urandom), rand_row3(zero_pct), rand_row3(zero_pct),
                       rand_row3(zero_pct), rand_row3(zero_pct), rand_row4(zero_pct),
                       rand_row4(zero_pct), rand_row4(zero_pct));
            no_idle = (p == 0);
            if (p == 2)
                hold_request = 1'b1;
            run_random_phase(PHASE_SYMBOLS);
        end

        wait_drained();
        $display("ran %0d symbols over %0d table settings, %0d likelihoods checked (%0d saturated)",
                 symbols_sent, models_loaded, sb.checked, sb.saturated_totals);
        $display("state counts 0..3, log-zero and largest words, full output backpressure");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d errors, %0d likelihoods never arrived", sb.errors, sb.pending());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ hmm_forward_log_likelihood.f @@
+incdir+rtl
rtl/hfll_pkg.sv
rtl/hfll_alu.sv
rtl/hfll_cfg.sv
rtl/hmm_forward_log_likelihood.sv
dv/hmm_forward_log_likelihood_tb.sv
